// ----- hdl/pcr_pkg.sv -----
package pcr_pkg;

    // Port field widths
    localparam int VEC_W = 63;
    localparam int IM_W  = 20;
    localparam int BNC_W = 13;
    localparam int DEP_W = 21;
    localparam int FT_W  = 16;

    // Fixed fractions of restitution and frame time
    localparam int BNC_FRAC = 12;
    localparam int FT_FRAC  = 16;

    localparam logic [FT_W-1:0] FT_RESET = 16'd1092;

    // Queue between front and back
    localparam int Q_DEPTH = 4;

    // Division lanes: velocity share of A and B, position share of A and B
    localparam int NUM_LANES = 4;
    localparam int L_AV = 0;
    localparam int L_BV = 1;
    localparam int L_AP = 2;
    localparam int L_BP = 3;

    typedef struct packed {
        logic impulse;
        logic moved;
    } t_flags;

    // Quotient width: separating-velocity change, or positive depth if wider
    function automatic int qbits(input int comp_bits, input int frac_bits);
        int sep_w;
        sep_w = 2 * comp_bits + 3 - frac_bits;
        return (sep_w + 1 > DEP_W - 1) ? sep_w + 1 : DEP_W - 1;
    endfunction

endpackage

// ----- hdl/pcr_if.sv -----
interface pcr_in_if;
    logic                        valid;
    logic                        ready;
    logic [pcr_pkg::VEC_W-1:0]   vel_a;
    logic [pcr_pkg::VEC_W-1:0]   vel_b;
    logic [pcr_pkg::VEC_W-1:0]   acc_a;
    logic [pcr_pkg::VEC_W-1:0]   acc_b;
    logic [pcr_pkg::VEC_W-1:0]   normal_dir;
    logic [pcr_pkg::IM_W-1:0]    inv_mass_a;
    logic [pcr_pkg::IM_W-1:0]    inv_mass_b;
    logic                        has_b;
    logic [pcr_pkg::BNC_W-1:0]   bounce;
    logic signed [pcr_pkg::DEP_W-1:0] depth;

    modport source (
        output valid, vel_a, vel_b, acc_a, acc_b, normal_dir,
               inv_mass_a, inv_mass_b, has_b, bounce, depth,
        input  ready
    );
    modport sink (
        input  valid, vel_a, vel_b, acc_a, acc_b, normal_dir,
               inv_mass_a, inv_mass_b, has_b, bounce, depth,
        output ready
    );
endinterface

interface pcr_out_if;
    logic                        valid;
    logic                        ready;
    logic [pcr_pkg::VEC_W-1:0]   new_vel_a;
    logic [pcr_pkg::VEC_W-1:0]   new_vel_b;
    logic [pcr_pkg::VEC_W-1:0]   shift_a;
    logic [pcr_pkg::VEC_W-1:0]   shift_b;
    logic                        impulse_done;
    logic                        moved;

    modport source (
        output valid, new_vel_a, new_vel_b, shift_a, shift_b, impulse_done, moved,
        input  ready
    );
    modport sink (
        input  valid, new_vel_a, new_vel_b, shift_a, shift_b, impulse_done, moved,
        output ready
    );
endinterface

// ----- hdl/pcr_front.sv -----
module pcr_front #(
    parameter int COMP_BITS = 21,
    parameter int FRAC_BITS = 12,
    localparam int QW   = pcr_pkg::qbits(COMP_BITS, FRAC_BITS),
    localparam int TOTW = pcr_pkg::IM_W + 1,
    localparam int NW   = QW + TOTW
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    pcr_in_if.sink                    i_in,
    input  logic [pcr_pkg::FT_W-1:0]  i_frame_time,
    input  logic                      i_full,
    output logic                      o_valid,
    output pcr_pkg::t_flags           o_flags,
    output logic [3*COMP_BITS-1:0]    o_va,
    output logic [3*COMP_BITS-1:0]    o_vb,
    output logic [3*COMP_BITS-1:0]    o_n,
    output logic [TOTW-1:0]           o_den,
    output logic [NW-1:0]             o_num [pcr_pkg::NUM_LANES]
);

    localparam int C    = COMP_BITS;
    localparam int VW   = 3 * C;
    localparam int RW   = C + 1;
    localparam int PW   = 2 * C + 1;
    localparam int DOTW = 2 * C + 3;
    localparam int SEPW = DOTW - FRAC_BITS;
    localparam int BW   = pcr_pkg::BNC_W + 1;
    localparam int PTW  = SEPW + 1 + BW;
    localparam int PAW  = SEPW + pcr_pkg::FT_W + 1;
    localparam int PBW  = SEPW + 1 + BW;
    localparam int TGW  = SEPW + 2;
    localparam int DVW  = QW + 2;

    logic       en;
    logic [5:0] r_vld;

    // Advance the whole front unless its last word cannot enter the queue
    assign en          = !r_vld[5] || !i_full;
    assign i_in.ready  = en;
    assign o_valid     = r_vld[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[4:0], i_in.valid};
        end
    end

    // Stage 1: relative vectors times normal
    logic signed [C-1:0]  c_va [3];
    logic signed [C-1:0]  c_vb [3];
    logic signed [C-1:0]  c_aa [3];
    logic signed [C-1:0]  c_ab [3];
    logic signed [C-1:0]  c_n  [3];
    logic signed [RW-1:0] c_rv [3];
    logic signed [RW-1:0] c_ra [3];
    logic signed [PW-1:0] n_s1_pv [3];
    logic signed [PW-1:0] n_s1_pa [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_va[i] = i_in.vel_a[i*C +: C];
            c_vb[i] = i_in.vel_b[i*C +: C];
            c_aa[i] = i_in.acc_a[i*C +: C];
            c_ab[i] = i_in.acc_b[i*C +: C];
            c_n[i]  = i_in.normal_dir[i*C +: C];
            c_rv[i] = RW'(c_va[i]) - (i_in.has_b ? RW'(c_vb[i]) : RW'(0));
            c_ra[i] = RW'(c_aa[i]) - (i_in.has_b ? RW'(c_ab[i]) : RW'(0));
            n_s1_pv[i] = c_rv[i] * c_n[i];
            n_s1_pa[i] = c_ra[i] * c_n[i];
        end
    end

    logic signed [PW-1:0]            r_s1_pv [3];
    logic signed [PW-1:0]            r_s1_pa [3];
    logic [VW-1:0]                   r_s1_va, r_s1_vb, r_s1_n;
    logic [pcr_pkg::IM_W-1:0]        r_s1_ima, r_s1_imb;
    logic [pcr_pkg::BNC_W-1:0]       r_s1_bnc;
    logic signed [pcr_pkg::DEP_W-1:0] r_s1_dep;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_pv  <= n_s1_pv;
            r_s1_pa  <= n_s1_pa;
            r_s1_va  <= i_in.vel_a[VW-1:0];
            r_s1_vb  <= i_in.vel_b[VW-1:0];
            r_s1_n   <= i_in.normal_dir[VW-1:0];
            r_s1_ima <= i_in.inv_mass_a;
            r_s1_imb <= i_in.has_b ? i_in.inv_mass_b : '0;
            r_s1_bnc <= i_in.bounce;
            r_s1_dep <= i_in.depth;
        end
    end

    // Stage 2: dot products, scale down, total inverse mass
    logic signed [DOTW-1:0] c_dotv, c_dota, c_dotv_sh, c_dota_sh;
    logic signed [SEPW-1:0] n_s2_sep, n_s2_das;
    logic [TOTW-1:0]        n_s2_tot;

    always_comb begin
        c_dotv    = DOTW'(r_s1_pv[0]) + DOTW'(r_s1_pv[1]) + DOTW'(r_s1_pv[2]);
        c_dota    = DOTW'(r_s1_pa[0]) + DOTW'(r_s1_pa[1]) + DOTW'(r_s1_pa[2]);
        c_dotv_sh = c_dotv >>> FRAC_BITS;
        c_dota_sh = c_dota >>> FRAC_BITS;
        n_s2_sep  = c_dotv_sh[SEPW-1:0];
        n_s2_das  = c_dota_sh[SEPW-1:0];
        n_s2_tot  = TOTW'(r_s1_ima) + TOTW'(r_s1_imb);
    end

    logic signed [SEPW-1:0]          r_s2_sep, r_s2_das;
    logic [TOTW-1:0]                 r_s2_tot;
    logic [VW-1:0]                   r_s2_va, r_s2_vb, r_s2_n;
    logic [pcr_pkg::IM_W-1:0]        r_s2_ima, r_s2_imb;
    logic [pcr_pkg::BNC_W-1:0]       r_s2_bnc;
    logic signed [pcr_pkg::DEP_W-1:0] r_s2_dep;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_sep <= n_s2_sep;
            r_s2_das <= n_s2_das;
            r_s2_tot <= n_s2_tot;
            r_s2_va  <= r_s1_va;
            r_s2_vb  <= r_s1_vb;
            r_s2_n   <= r_s1_n;
            r_s2_ima <= r_s1_ima;
            r_s2_imb <= r_s1_imb;
            r_s2_bnc <= r_s1_bnc;
            r_s2_dep <= r_s1_dep;
        end
    end

    // Stage 3: restitution and acceleration products, classify the contact
    logic signed [SEPW:0]   c_neg_sep;
    logic signed [PTW-1:0]  n_s3_ptgt;
    logic signed [PAW-1:0]  n_s3_pacc;
    pcr_pkg::t_flags        n_s3_flags;

    always_comb begin
        c_neg_sep          = -(SEPW+1)'(r_s2_sep);
        n_s3_ptgt          = c_neg_sep * $signed({1'b0, r_s2_bnc});
        n_s3_pacc          = r_s2_das * $signed({1'b0, i_frame_time});
        n_s3_flags.impulse = (r_s2_sep <= 0) && (r_s2_tot != '0);
        n_s3_flags.moved   = (r_s2_dep > 0) && (r_s2_tot != '0);
    end

    logic signed [PTW-1:0]           r_s3_ptgt;
    logic signed [PAW-1:0]           r_s3_pacc;
    logic signed [SEPW-1:0]          r_s3_sep;
    logic [TOTW-1:0]                 r_s3_tot;
    pcr_pkg::t_flags                 r_s3_flags;
    logic [VW-1:0]                   r_s3_va, r_s3_vb, r_s3_n;
    logic [pcr_pkg::IM_W-1:0]        r_s3_ima, r_s3_imb;
    logic [pcr_pkg::BNC_W-1:0]       r_s3_bnc;
    logic signed [pcr_pkg::DEP_W-1:0] r_s3_dep;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_ptgt  <= n_s3_ptgt;
            r_s3_pacc  <= n_s3_pacc;
            r_s3_sep   <= r_s2_sep;
            r_s3_tot   <= r_s2_tot;
            r_s3_flags <= n_s3_flags;
            r_s3_va    <= r_s2_va;
            r_s3_vb    <= r_s2_vb;
            r_s3_n     <= r_s2_n;
            r_s3_ima   <= r_s2_ima;
            r_s3_imb   <= r_s2_imb;
            r_s3_bnc   <= r_s2_bnc;
            r_s3_dep   <= r_s2_dep;
        end
    end

    // Stage 4: base target, scaled acceleration, restitution on it
    logic signed [PTW-1:0]  c_tgt_sh;
    logic signed [PAW-1:0]  c_acc_sh;
    logic signed [SEPW:0]   n_s4_tgt0;
    logic signed [SEPW:0]   c_accs;
    logic signed [PBW-1:0]  n_s4_pbacc;

    always_comb begin
        c_tgt_sh   = r_s3_ptgt >>> pcr_pkg::BNC_FRAC;
        c_acc_sh   = r_s3_pacc >>> pcr_pkg::FT_FRAC;
        n_s4_tgt0  = c_tgt_sh[SEPW:0];
        c_accs     = c_acc_sh[SEPW:0];
        n_s4_pbacc = c_accs * $signed({1'b0, r_s3_bnc});
    end

    logic signed [SEPW:0]            r_s4_tgt0;
    logic signed [PBW-1:0]           r_s4_pbacc;
    logic                            r_s4_neg;
    logic signed [SEPW-1:0]          r_s4_sep;
    logic [TOTW-1:0]                 r_s4_tot;
    pcr_pkg::t_flags                 r_s4_flags;
    logic [VW-1:0]                   r_s4_va, r_s4_vb, r_s4_n;
    logic [pcr_pkg::IM_W-1:0]        r_s4_ima, r_s4_imb;
    logic signed [pcr_pkg::DEP_W-1:0] r_s4_dep;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_tgt0  <= n_s4_tgt0;
            r_s4_pbacc <= n_s4_pbacc;
            r_s4_neg   <= c_accs[SEPW];
            r_s4_sep   <= r_s3_sep;
            r_s4_tot   <= r_s3_tot;
            r_s4_flags <= r_s3_flags;
            r_s4_va    <= r_s3_va;
            r_s4_vb    <= r_s3_vb;
            r_s4_n     <= r_s3_n;
            r_s4_ima   <= r_s3_ima;
            r_s4_imb   <= r_s3_imb;
            r_s4_dep   <= r_s3_dep;
        end
    end

    // Stage 5: final target, velocity change and penetration to share out
    logic signed [PBW-1:0] c_bt_sh;
    logic signed [TGW-1:0] c_sum, c_tgt;
    logic signed [DVW-1:0] c_dv;
    logic [QW-1:0]         n_s5_dv, n_s5_dq;

    always_comb begin
        c_bt_sh = r_s4_pbacc >>> pcr_pkg::BNC_FRAC;
        c_sum   = TGW'(r_s4_tgt0) + c_bt_sh[TGW-1:0];
        if (r_s4_neg) begin
            c_tgt = (c_sum < 0) ? TGW'(0) : c_sum;
        end else begin
            c_tgt = TGW'(r_s4_tgt0);
        end
        c_dv    = DVW'(c_tgt) - DVW'(r_s4_sep);
        n_s5_dv = r_s4_flags.impulse ? c_dv[QW-1:0] : '0;
        n_s5_dq = r_s4_flags.moved ? QW'(r_s4_dep[pcr_pkg::DEP_W-2:0]) : '0;
    end

    logic [QW-1:0]            r_s5_dv, r_s5_dq;
    logic [TOTW-1:0]          r_s5_tot;
    pcr_pkg::t_flags          r_s5_flags;
    logic [VW-1:0]            r_s5_va, r_s5_vb, r_s5_n;
    logic [pcr_pkg::IM_W-1:0] r_s5_ima, r_s5_imb;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5_dv    <= n_s5_dv;
            r_s5_dq    <= n_s5_dq;
            r_s5_tot   <= r_s4_tot;
            r_s5_flags <= r_s4_flags;
            r_s5_va    <= r_s4_va;
            r_s5_vb    <= r_s4_vb;
            r_s5_n     <= r_s4_n;
            r_s5_ima   <= r_s4_ima;
            r_s5_imb   <= r_s4_imb;
        end
    end

    // Stage 6: numerators of the four shares; a zero total divides by one
    logic [NW-1:0]   n_s6_num [pcr_pkg::NUM_LANES];
    logic [TOTW-1:0] n_s6_den;

    always_comb begin
        n_s6_num[pcr_pkg::L_AV] = r_s5_dv * r_s5_ima;
        n_s6_num[pcr_pkg::L_BV] = r_s5_dv * r_s5_imb;
        n_s6_num[pcr_pkg::L_AP] = r_s5_dq * r_s5_ima;
        n_s6_num[pcr_pkg::L_BP] = r_s5_dq * r_s5_imb;
        n_s6_den = (r_s5_tot == '0) ? TOTW'(1) : r_s5_tot;
    end

    logic [NW-1:0]   r_s6_num [pcr_pkg::NUM_LANES];
    logic [TOTW-1:0] r_s6_den;
    pcr_pkg::t_flags r_s6_flags;
    logic [VW-1:0]   r_s6_va, r_s6_vb, r_s6_n;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s6_num   <= n_s6_num;
            r_s6_den   <= n_s6_den;
            r_s6_flags <= r_s5_flags;
            r_s6_va    <= r_s5_va;
            r_s6_vb    <= r_s5_vb;
            r_s6_n     <= r_s5_n;
        end
    end

    assign o_num   = r_s6_num;
    assign o_den   = r_s6_den;
    assign o_flags = r_s6_flags;
    assign o_va    = r_s6_va;
    assign o_vb    = r_s6_vb;
    assign o_n     = r_s6_n;

endmodule

// ----- hdl/pcr_queue.sv -----
module pcr_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    // Wrap pointers at the depth
    assign n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue read while empty");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not advance on write");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop && !i_push |=> r_count == $past(r_count) - 1'b1)
        else $error("queue count did not drop on read");

endmodule

// ----- hdl/pcr_back.sv -----
module pcr_back #(
    parameter int COMP_BITS = 21,
    parameter int FRAC_BITS = 12,
    localparam int QW   = pcr_pkg::qbits(COMP_BITS, FRAC_BITS),
    localparam int TOTW = pcr_pkg::IM_W + 1,
    localparam int NW   = QW + TOTW
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_pop,
    input  pcr_pkg::t_flags        i_flags,
    input  logic [3*COMP_BITS-1:0] i_va,
    input  logic [3*COMP_BITS-1:0] i_vb,
    input  logic [3*COMP_BITS-1:0] i_n,
    input  logic [TOTW-1:0]        i_den,
    input  logic [NW-1:0]          i_num [pcr_pkg::NUM_LANES],
    pcr_out_if.source              o_out
);

    localparam int C   = COMP_BITS;
    localparam int VW  = 3 * C;
    localparam int SDW = 3 * VW + 2;
    localparam int MW  = C + QW + 1;
    localparam int EW  = MW + 1;
    localparam int NL  = pcr_pkg::NUM_LANES;

    localparam logic signed [EW-1:0] SAT_HI = EW'(2 ** (COMP_BITS - 1) - 1);
    localparam logic signed [EW-1:0] SAT_LO = ~SAT_HI;

    // One restoring step: shift in the next numerator bit, subtract if it fits
    function automatic logic [NW-1:0] div_step(input logic [NW-1:0] rq,
                                               input logic [TOTW-1:0] d);
        logic [TOTW:0] shv;
        logic [TOTW:0] diff;
        logic          ge;
        shv  = {rq[NW-1:QW], rq[QW-1]};
        diff = shv - {1'b0, d};
        ge   = (shv >= {1'b0, d});
        return {ge ? diff[TOTW-1:0] : shv[TOTW-1:0], rq[QW-2:0], ge};
    endfunction

    function automatic logic [C-1:0] sat_c(input logic signed [EW-1:0] x);
        logic signed [EW-1:0] y;
        y = x;
        if (x > SAT_HI) begin
            y = SAT_HI;
        end else if (x < SAT_LO) begin
            y = SAT_LO;
        end
        return y[C-1:0];
    endfunction

    logic en;
    logic r_ov;
    logic r_pv;
    logic [QW:0] r_dv;

    // Advance the whole back end unless the output word is held
    assign en          = !r_ov || o_out.ready;
    assign o_pop       = en && i_valid;
    assign o_out.valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_dv <= {r_dv[QW-1:0], i_valid};
            r_pv <= r_dv[QW];
            r_ov <= r_pv;
        end
    end

    // Quotient pipeline: one bit per stage, four lanes share the divisor
    logic [NW-1:0]   r_rq   [QW+1][NL];
    logic [NW-1:0]   n_rq   [QW+1][NL];
    logic [TOTW-1:0] r_den  [QW+1];
    logic [SDW-1:0]  r_side [QW+1];

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            n_rq[0][l] = i_num[l];
        end
        for (int k = 0; k < QW; k++) begin
            for (int l = 0; l < NL; l++) begin
                n_rq[k+1][l] = div_step(r_rq[k][l], r_den[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rq      <= n_rq;
            r_den[0]  <= i_den;
            r_side[0] <= {i_flags, i_n, i_vb, i_va};
            for (int k = 0; k < QW; k++) begin
                r_den[k+1]  <= r_den[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    // Apply: normal times each share
    logic signed [C-1:0]  c_n [3];
    logic signed [MW-1:0] n_pm [NL][3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_n[i] = r_side[QW][2*VW + i*C +: C];
            for (int l = 0; l < NL; l++) begin
                n_pm[l][i] = c_n[i] * $signed({1'b0, r_rq[QW][l][QW-1:0]});
            end
        end
    end

    logic signed [MW-1:0] r_pm [NL][3];
    logic [VW-1:0]        r_pva, r_pvb;
    pcr_pkg::t_flags      r_pflags;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pm     <= n_pm;
            r_pva    <= r_side[QW][VW-1:0];
            r_pvb    <= r_side[QW][2*VW-1:VW];
            r_pflags <= r_side[QW][SDW-1:SDW-2];
        end
    end

    // Scale down, add to velocities, saturate and pack
    logic signed [MW-1:0] c_d [NL][3];
    logic signed [C-1:0]  c_va [3];
    logic signed [C-1:0]  c_vb [3];
    logic [VW-1:0]        c_nva, c_nvb, c_sa, c_sb;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int l = 0; l < NL; l++) begin
                c_d[l][i] = r_pm[l][i] >>> FRAC_BITS;
            end
            c_va[i] = r_pva[i*C +: C];
            c_vb[i] = r_pvb[i*C +: C];
            c_nva[i*C +: C] = sat_c(EW'(c_va[i]) + EW'(c_d[pcr_pkg::L_AV][i]));
            c_nvb[i*C +: C] = sat_c(EW'(c_vb[i]) - EW'(c_d[pcr_pkg::L_BV][i]));
            c_sa[i*C +: C]  = sat_c(EW'(c_d[pcr_pkg::L_AP][i]));
            c_sb[i*C +: C]  = sat_c(-EW'(c_d[pcr_pkg::L_BP][i]));
        end
    end

    logic [pcr_pkg::VEC_W-1:0] r_nva, r_nvb, r_sa, r_sb;
    pcr_pkg::t_flags           r_oflags;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nva    <= pcr_pkg::VEC_W'(c_nva);
            r_nvb    <= pcr_pkg::VEC_W'(c_nvb);
            r_sa     <= pcr_pkg::VEC_W'(c_sa);
            r_sb     <= pcr_pkg::VEC_W'(c_sb);
            r_oflags <= r_pflags;
        end
    end

    assign o_out.new_vel_a    = r_nva;
    assign o_out.new_vel_b    = r_nvb;
    assign o_out.shift_a      = r_sa;
    assign o_out.shift_b      = r_sb;
    assign o_out.impulse_done = r_oflags.impulse;
    assign o_out.moved        = r_oflags.moved;

endmodule

// ----- hdl/particle_contact_resolver_core.sv -----
// Quotient width QW = max(2*COMP_BITS - FRAC_BITS + 4, 20); 34 at the defaults.
// Throughput: one word per cycle unless the output word is held; the share division is an unrolled
//   restoring pipeline, one quotient bit per stage, four lanes wide.
// Reset: synchronous, active low; clears all valid bits and the queue, and
//   sets frame_time to 1092.
module particle_contact_resolver_core #(
    parameter int COMP_BITS = 21,
    parameter int FRAC_BITS = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [pcr_pkg::FT_W-1:0] i_cfg_wdata,
    pcr_in_if.sink                   i_in,
    pcr_out_if.source                o_out
);

    localparam int QW   = pcr_pkg::qbits(COMP_BITS, FRAC_BITS);
    localparam int TOTW = pcr_pkg::IM_W + 1;
    localparam int NW   = QW + TOTW;
    localparam int VW   = 3 * COMP_BITS;
    localparam int QDW  = 2 + 3 * VW + TOTW + pcr_pkg::NUM_LANES * NW;

    // Frame time register
    logic [pcr_pkg::FT_W-1:0] r_frame_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_time <= pcr_pkg::FT_RESET;
        end else if (i_cfg_we) begin
            r_frame_time <= i_cfg_wdata;
        end
    end

    // Front: products, target velocity, share numerators
    logic            f_valid;
    pcr_pkg::t_flags f_flags;
    logic [VW-1:0]   f_va, f_vb, f_n;
    logic [TOTW-1:0] f_den;
    logic [NW-1:0]   f_num [pcr_pkg::NUM_LANES];

    // Queue between front and back
    logic            q_full, q_empty, q_push, q_pop;
    logic [QDW-1:0]  q_wdata, q_rdata;
    pcr_pkg::t_flags b_flags;
    logic [VW-1:0]   b_va, b_vb, b_n;
    logic [TOTW-1:0] b_den;
    logic [NW-1:0]   b_num [pcr_pkg::NUM_LANES];

    pcr_front #(
        .COMP_BITS (COMP_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_frame_time (r_frame_time),
        .i_full       (q_full),
        .o_valid      (f_valid),
        .o_flags      (f_flags),
        .o_va         (f_va),
        .o_vb         (f_vb),
        .o_n          (f_n),
        .o_den        (f_den),
        .o_num        (f_num)
    );

    assign q_push  = f_valid && !q_full;
    assign q_wdata = {f_flags, f_va, f_vb, f_n, f_den,
                      f_num[pcr_pkg::L_AV], f_num[pcr_pkg::L_BV],
                      f_num[pcr_pkg::L_AP], f_num[pcr_pkg::L_BP]};
    assign {b_flags, b_va, b_vb, b_n, b_den,
            b_num[pcr_pkg::L_AV], b_num[pcr_pkg::L_BV],
            b_num[pcr_pkg::L_AP], b_num[pcr_pkg::L_BP]} = q_rdata;

    pcr_queue #(
        .W     (QDW),
        .DEPTH (pcr_pkg::Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // Back: division, apply along the normal, saturate
    pcr_back #(
        .COMP_BITS (COMP_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!q_empty),
        .o_pop   (q_pop),
        .i_flags (b_flags),
        .i_va    (b_va),
        .i_vb    (b_vb),
        .i_n     (b_n),
        .i_den   (b_den),
        .i_num   (b_num),
        .o_out   (o_out)
    );

endmodule
